[design/bfe_pkg.sv]
// Shared types, constants and hash helpers for the bloom filter engine.
// No dependencies.
package bfe_pkg;

    localparam int FILTER_BITS_DEF = 65536;
    localparam int MAX_HASHES_DEF  = 16;

    localparam int KEY_W     = 32;
    localparam int OP_W      = 2;
    localparam int CFG_W     = 17;
    localparam int NHASH_W   = 5;
    localparam int MOD_STEP  = 4;
    localparam int MOD_CYC   = KEY_W / MOD_STEP;
    localparam int MODCNT_W  = $clog2(MOD_CYC);

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic REG_NUM_BITS   = 1'b0;
    localparam logic REG_NUM_HASHES = 1'b1;

    localparam logic [CFG_W-1:0]   NUM_BITS_RST   = 17'd65536;
    localparam logic [NHASH_W-1:0] NUM_HASHES_RST = 5'd7;

    typedef struct packed {
        logic ins;
        logic qry;
        logic clr;
    } cls_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        cls_t             cls;
    } item_t;

    // first half of the mixer: shift/xor/add steps
    function automatic logic [KEY_W-1:0] mix_a(input logic [KEY_W-1:0] x);
        logic [KEY_W-1:0] v;
        v = ~x + (x << 15);
        v = v ^ (v >> 12);
        v = v + (v << 2);
        v = v ^ (v >> 4);
        return v;
    endfunction

    // second half: times 2057 (= 2048 + 8 + 1), then fold
    function automatic logic [KEY_W-1:0] mix_b(input logic [KEY_W-1:0] x);
        logic [KEY_W-1:0] v;
        v = x + (x << 3) + (x << 11);
        v = v ^ (v >> 16);
        return v;
    endfunction

endpackage

[design/bfe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/bfe_front.sv]
// Front end: accepts items, classifies the opcode, holds them in a 2-entry queue.
// Depends on bfe_pkg.
module bfe_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [bfe_pkg::OP_W-1:0]      opcode,
    input  logic [bfe_pkg::KEY_W-1:0]     key,
    output logic                          q_full,
    output logic                          q_valid,
    output bfe_pkg::item_t                q_item,
    input  logic                          q_pop
);

    bfe_pkg::item_t slot_reg [2];
    logic           wptr_reg, wptr_next;
    logic           rptr_reg, rptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    bfe_pkg::item_t in_item;
    logic           do_push, do_pop;

    always_comb
    begin
        in_item.op      = opcode;
        in_item.key     = key;
        in_item.cls.ins = (opcode == bfe_pkg::OP_INSERT);
        in_item.cls.qry = (opcode == bfe_pkg::OP_QUERY);
        in_item.cls.clr = (opcode == bfe_pkg::OP_CLEAR);
    end

    assign q_full  = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = slot_reg[rptr_reg];
    assign do_push = push && !q_full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        wptr_next = do_push ? ~wptr_reg : wptr_reg;
        rptr_next = do_pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= in_item;
        end
    end

endmodule

[design/bfe_back.sv]
// Back end: hash sequencer, iterative modulo, bit store and clearing sweep.
// Depends on bfe_pkg and bfe_ram.
module bfe_back #(
    parameter int FILTER_BITS = bfe_pkg::FILTER_BITS_DEF,
    parameter int MAX_HASHES  = bfe_pkg::MAX_HASHES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [bfe_pkg::CFG_W-1:0]     num_bits,
    input  logic [bfe_pkg::NHASH_W-1:0]   num_hashes,
    input  logic                          q_valid,
    input  bfe_pkg::item_t                q_item,
    output logic                          q_pop,
    output logic                          res_valid,
    output logic [bfe_pkg::OP_W-1:0]      res_op,
    output logic                          res_flag,
    input  logic                          res_take,
    output logic                          init_busy,
    output logic                          clr_write
);

    localparam int STORE_BYTES = (FILTER_BITS + 7) / 8;
    localparam int AW  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int MW  = $clog2(FILTER_BITS + 1);
    localparam int KW0 = $clog2(MAX_HASHES + 1);
    localparam int KW  = (KW0 > bfe_pkg::NHASH_W) ? KW0 : bfe_pkg::NHASH_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MIX  = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_MOD  = 7'b0001000,
        S_RD   = 7'b0010000,
        S_CHK  = 7'b0100000,
        S_CLR  = 7'b1000000
    } state_t;

    state_t                       state_reg, state_next;
    logic                         init_reg, init_next;
    logic [AW-1:0]                clr_addr_reg, clr_addr_next;
    logic [bfe_pkg::OP_W-1:0]     op_reg, op_next;
    logic [bfe_pkg::KEY_W-1:0]    key_reg, key_next;
    logic                         ins_reg, ins_next;
    logic                         flag_reg, flag_next;
    logic [KW-1:0]                idx_reg, idx_next;
    logic [bfe_pkg::KEY_W-1:0]    hash_reg, hash_next;
    logic [MW-1:0]                rem_reg, rem_next;
    logic [bfe_pkg::MODCNT_W-1:0] mcnt_reg, mcnt_next;
    logic                         rv_reg, rv_next;
    logic [bfe_pkg::OP_W-1:0]     rop_reg, rop_next;
    logic                         rflag_reg, rflag_next;

    logic [31:0]   nb32, m32;
    logic [MW-1:0] m_eff;
    logic [KW-1:0] k_eff;
    logic [MW:0]   rem_w;
    logic [bfe_pkg::KEY_W-1:0] hash_sh;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;
    logic [7:0]    bit_mask;
    logic          last_idx;

    // effective bit count and hash count
    always_comb
    begin
        nb32 = 32'(num_bits);
        if (nb32 == 32'd0)
        begin
            m32 = 32'd1;
        end
        else if (nb32 > 32'(FILTER_BITS))
        begin
            m32 = 32'(FILTER_BITS);
        end
        else
        begin
            m32 = nb32;
        end
        m_eff = MW'(m32);
        if (KW'(num_hashes) > KW'(MAX_HASHES))
        begin
            k_eff = KW'(MAX_HASHES);
        end
        else
        begin
            k_eff = KW'(num_hashes);
        end
    end

    // restoring remainder, MOD_STEP bits per cycle
    always_comb
    begin
        rem_w   = {1'b0, rem_reg};
        hash_sh = hash_reg;
        for (int j = 0; j < bfe_pkg::MOD_STEP; j++)
        begin
            rem_w   = {rem_w[MW-1:0], hash_sh[bfe_pkg::KEY_W-1]};
            hash_sh = hash_sh << 1;
            if (rem_w >= {1'b0, m_eff})
            begin
                rem_w = rem_w - {1'b0, m_eff};
            end
        end
    end

    assign bit_mask  = 8'(1) << rem_reg[2:0];
    assign ram_raddr = AW'(rem_reg >> 3);
    assign last_idx  = ((idx_reg + KW'(1)) == k_eff);

    always_comb
    begin
        state_next    = state_reg;
        init_next     = init_reg;
        clr_addr_next = clr_addr_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        ins_next      = ins_reg;
        flag_next     = flag_reg;
        idx_next      = idx_reg;
        hash_next     = hash_reg;
        rem_next      = rem_reg;
        mcnt_next     = mcnt_reg;
        rv_next       = rv_reg && !res_take;
        rop_next      = rop_reg;
        rflag_next    = rflag_reg;
        q_pop         = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = ram_raddr;
        ram_wdata     = ram_rdata | bit_mask;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && !rv_reg)
                begin
                    q_pop     = 1'b1;
                    op_next   = q_item.op;
                    key_next  = q_item.key;
                    ins_next  = q_item.cls.ins;
                    flag_next = q_item.cls.qry;
                    idx_next  = '0;
                    if (q_item.cls.clr)
                    begin
                        clr_addr_next = '0;
                        state_next    = S_CLR;
                    end
                    else if ((q_item.cls.ins || q_item.cls.qry) && (k_eff != '0))
                    begin
                        state_next = S_MIX;
                    end
                    else
                    begin
                        rv_next    = 1'b1;
                        rop_next   = q_item.op;
                        rflag_next = q_item.cls.qry;
                    end
                end
            end
            S_MIX:
            begin
                hash_next  = bfe_pkg::mix_a(key_reg + bfe_pkg::KEY_W'(idx_reg));
                state_next = S_MUL;
            end
            S_MUL:
            begin
                hash_next  = bfe_pkg::mix_b(hash_reg);
                rem_next   = '0;
                mcnt_next  = '0;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                rem_next  = rem_w[MW-1:0];
                hash_next = hash_sh;
                mcnt_next = mcnt_reg + bfe_pkg::MODCNT_W'(1);
                if (mcnt_reg == bfe_pkg::MODCNT_W'(bfe_pkg::MOD_CYC - 1))
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                ram_we = ins_reg;
                if (!ins_reg && ((ram_rdata & bit_mask) == 8'd0))
                begin
                    rv_next    = 1'b1;
                    rop_next   = op_reg;
                    rflag_next = 1'b0;
                    state_next = S_IDLE;
                end
                else if (last_idx)
                begin
                    rv_next    = 1'b1;
                    rop_next   = op_reg;
                    rflag_next = flag_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + KW'(1);
                    state_next = S_MIX;
                end
            end
            S_CLR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = 8'd0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                    if (init_reg)
                    begin
                        init_next = 1'b0;
                    end
                    else
                    begin
                        rv_next    = 1'b1;
                        rop_next   = op_reg;
                        rflag_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            init_reg     <= 1'b1;
            clr_addr_reg <= '0;
            rv_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            init_reg     <= init_next;
            clr_addr_reg <= clr_addr_next;
            rv_reg       <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        ins_reg   <= ins_next;
        flag_reg  <= flag_next;
        idx_reg   <= idx_next;
        hash_reg  <= hash_next;
        rem_reg   <= rem_next;
        mcnt_reg  <= mcnt_next;
        rop_reg   <= rop_next;
        rflag_reg <= rflag_next;
    end

    bfe_ram #(
        .WIDTH(8),
        .DEPTH(STORE_BYTES)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign res_valid = rv_reg;
    assign res_op    = rop_reg;
    assign res_flag  = rflag_reg;
    assign init_busy = init_reg;
    assign clr_write = (state_reg == S_CLR) && (ram_wdata == 8'd0) && ram_we;

endmodule

[design/bloom_filter_engine.sv]
// Bloom filter engine: per hash, mixing (S_MIX, S_MUL), an iterative modulo in S_MOD
// (4 remainder bits a cycle), 1 read and 1 check/update of the byte store.
// Insert/query repeat these steps for each of the k hashes; a query may stop early.
// Clear sweeps the store one byte a cycle.
// After reset the same sweep runs while full stays high.
// Depends on bfe_pkg, bfe_front, bfe_back, bfe_ram.
module bloom_filter_engine #(
    parameter int FILTER_BITS = bfe_pkg::FILTER_BITS_DEF,
    parameter int MAX_HASHES  = bfe_pkg::MAX_HASHES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [bfe_pkg::OP_W-1:0]      opcode,
    input  logic [bfe_pkg::KEY_W-1:0]     key,
    output logic                          empty,
    input  logic                          pop,
    output logic [bfe_pkg::OP_W-1:0]      done_opcode,
    output logic                          maybe_present,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [bfe_pkg::CFG_W-1:0]     cfg_data
);

    logic [bfe_pkg::CFG_W-1:0]   num_bits_reg;
    logic [bfe_pkg::NHASH_W-1:0] num_hashes_reg;
    logic           q_full, q_valid, q_pop;
    bfe_pkg::item_t q_item;
    logic           res_valid, init_busy, clr_write;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_bits_reg   <= bfe_pkg::NUM_BITS_RST;
            num_hashes_reg <= bfe_pkg::NUM_HASHES_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == bfe_pkg::REG_NUM_BITS)
            begin
                num_bits_reg <= cfg_data;
            end
            else
            begin
                num_hashes_reg <= cfg_data[bfe_pkg::NHASH_W-1:0];
            end
        end
    end

    bfe_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push && !init_busy),
        .opcode (opcode),
        .key    (key),
        .q_full (q_full),
        .q_valid(q_valid),
        .q_item (q_item),
        .q_pop  (q_pop)
    );

    bfe_back #(
        .FILTER_BITS(FILTER_BITS),
        .MAX_HASHES (MAX_HASHES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_bits  (num_bits_reg),
        .num_hashes(num_hashes_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_op    (done_opcode),
        .res_flag  (maybe_present),
        .res_take  (pop),
        .init_busy (init_busy),
        .clr_write (clr_write)
    );

    assign full  = q_full || init_busy;
    assign empty = !res_valid;

    // no result while the power-on sweep runs
    a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> empty)
        else $error("result during initial clear");

    // only queries can report presence
    a_flag_query: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (done_opcode != bfe_pkg::OP_QUERY)) |-> !maybe_present)
        else $error("presence flag on non-query");

    // a waiting result holds until popped
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(done_opcode) && $stable(maybe_present)))
        else $error("waiting result changed");

    // queue is never drained while a result is still waiting
    a_pop_gate: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (empty && !init_busy && !clr_write))
        else $error("back end took item with result pending");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for bloom_filter_engine: a queue-fed driver, a stalling
// receiver and an in-line bit-store predictor. Depends on bfe_pkg and the engine RTL.
module tb_top;
    import bfe_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int STORE_BITS = 65536;
    localparam int HASH_CAP   = 16;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int N_PHASES = 8;
    localparam int PHASE_ITEMS = 230;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct {
        logic [OP_W-1:0] op;
        logic            hit;
    } answer_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic [OP_W-1:0] opcode;
    logic [KEY_W-1:0] key;
    logic empty;
    logic pop;
    logic [OP_W-1:0] done_opcode;
    logic maybe_present;
    logic cfg_we;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_data;

    bloom_filter_engine dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .opcode(opcode), .key(key), .empty(empty), .pop(pop),
        .done_opcode(done_opcode), .maybe_present(maybe_present),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    req_t    pending_items[$];
    answer_t expected_answers[$];
    bit      filter_bits[STORE_BITS];
    logic [CFG_W-1:0]   model_nbits;
    logic [NHASH_W-1:0] model_nhash;
    logic [KEY_W-1:0]   key_pool[$];
    int  errors;
    int  cycles;
    int  accepted;
    bit  took;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] scramble(input logic [31:0] x);
        logic [31:0] v;
        v = ~x + (x << 15);
        v = v ^ (v >> 12);
        v = v + (v << 2);
        v = v ^ (v >> 4);
        v = v * 32'd2057;
        v = v ^ (v >> 16);
        return v;
    endfunction

    // applies one item to the filter copy, returns the answer it must produce
    function automatic answer_t filter_apply(input logic [OP_W-1:0] op,
                                             input logic [KEY_W-1:0] k);
        answer_t a;
        int unsigned m;
        int unsigned nh;
        int unsigned pos;
        a.op = op;
        a.hit = 1'b0;
        m = model_nbits;
        if (m == 0) m = 1;
        if (m > STORE_BITS) m = STORE_BITS;
        nh = model_nhash;
        if (nh > HASH_CAP) nh = HASH_CAP;
        if (op == OP_INSERT)
        begin
            for (int i = 0; i < nh; i++)
            begin
                pos = scramble(k + i) % m;
                filter_bits[pos] = 1'b1;
            end
        end
        else if (op == OP_QUERY)
        begin
            a.hit = 1'b1;
            for (int i = 0; i < nh; i++)
            begin
                pos = scramble(k + i) % m;
                if (!filter_bits[pos]) a.hit = 1'b0;
            end
        end
        else if (op == OP_CLEAR)
        begin
            foreach (filter_bits[j]) filter_bits[j] = 1'b0;
        end
        return a;
    endfunction

    // acceptance and result check, sampled at the rising edge
    always @(posedge clk)
    begin
        answer_t e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        took = 1'b0;
        if (rst_n && push && !full)
        begin
            expected_answers.push_back(filter_apply(opcode, key));
            accepted <= accepted + 1;
            took = 1'b1;
        end
        if (rst_n && pop && !empty)
        begin
            if (expected_answers.size() == 0)
            begin
                $error("unexpected result: done_opcode %0d", done_opcode);
                errors++;
            end
            else
            begin
                e = expected_answers.pop_front();
                if (done_opcode !== e.op)
                begin
                    $error("done_opcode: expected %0d, got %0d", e.op, done_opcode);
                    errors++;
                end
                if (maybe_present !== e.hit)
                begin
                    $error("maybe_present: expected %0d, got %0d", e.hit, maybe_present);
                    errors++;
                end
            end
        end
    end

    // sender: bursts of random length with random gaps
    int burst_left = 5;
    int gap_left = 0;
    always @(negedge clk)
    begin
        req_t r;
        if (rst_n && (!push || took))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                push <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                r = pending_items.pop_front();
                push <= 1'b1;
                opcode <= r.op;
                key <= r.key;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                push <= 1'b0;
        end
    end

    // receiver: own stall pattern, plus one long hold-off to back the block up
    int mode_left = 0;
    int stall_mode = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(negedge clk)
    begin
        if (!hold_done && accepted >= 100)
        begin
            hold_done <= 1'b1;
            hold_left <= 3000;
            pop <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(16, 96);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0: pop <= 1'b1;
                1: pop <= $urandom_range(0, 1);
                default: pop <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_NUM_BITS) model_nbits = val;
        else model_nhash = val[NHASH_W-1:0];
    endtask

    task automatic add_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k);
        req_t r;
        r.op = op;
        r.key = k;
        pending_items.push_back(r);
        if (op == OP_INSERT)
        begin
            key_pool.push_back(k);
            if (key_pool.size() > 64) void'(key_pool.pop_front());
        end
    endtask

    task automatic drain;
        do
        begin
            @(posedge clk);
            #2;
        end
        while (pending_items.size() > 0 || push || expected_answers.size() > 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic add_random(input int n);
        int sel;
        logic [OP_W-1:0] op;
        logic [KEY_W-1:0] k;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 999);
            if (sel < 420) op = OP_INSERT;
            else if (sel < 950) op = OP_QUERY;
            else if (sel < 965) op = OP_CLEAR;
            else op = OP_UNUSED;
            sel = $urandom_range(0, 9);
            if (sel < 5 && key_pool.size() > 0)
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else if (sel == 5)
                k = 32'hFFFF_FFFF - $urandom_range(0, 20);
            else
                k = $urandom;
            add_item(op, k);
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0]   nb_set[N_PHASES];
        logic [NHASH_W-1:0] nh_set[N_PHASES];
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        opcode = OP_INSERT;
        key = '0;
        cfg_we = 1'b0;
        cfg_index = REG_NUM_BITS;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        accepted = 0;
        took = 1'b0;
        model_nbits = NUM_BITS_RST;
        model_nhash = NUM_HASHES_RST;
        nb_set = '{17'd65536, 17'd1, 17'd0, 17'd131071, 17'd100, 17'd65535, 17'd4097, 17'd9};
        nh_set = '{5'd7, 5'd1, 5'd0, 5'd31, 5'd16, 5'd3, 5'd2, 5'd17};
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed items at the reset settings
        add_item(OP_QUERY, 32'h0);
        add_item(OP_INSERT, 32'h0);
        add_item(OP_QUERY, 32'h0);
        add_item(OP_INSERT, 32'hFFFF_FFFF);
        add_item(OP_QUERY, 32'hFFFF_FFFF);
        add_item(OP_QUERY, 32'hFFFF_FFFE);
        add_item(OP_INSERT, 32'hFFFF_FFFA);
        add_item(OP_QUERY, 32'hFFFF_FFFA);
        add_item(OP_UNUSED, 32'hA5A5_5A5A);
        add_item(OP_QUERY, 32'h8000_0000);
        add_item(OP_INSERT, 32'h5555_5555);
        add_item(OP_QUERY, 32'h5555_5555);
        add_item(OP_QUERY, 32'hAAAA_AAAA);
        add_item(OP_CLEAR, 32'h0);
        add_item(OP_QUERY, 32'h0);
        add_item(OP_QUERY, 32'h5555_5555);
        drain();

        for (int p = 0; p < N_PHASES; p++)
        begin
            write_reg(REG_NUM_BITS, nb_set[p]);
            write_reg(REG_NUM_HASHES, {{(CFG_W-NHASH_W){1'b0}}, nh_set[p]});
            if (nh_set[p] == 0 || nb_set[p] < 2)
            begin
                // degenerate settings: still touch query and insert explicitly
                add_item(OP_QUERY, 32'h1234_5678);
                add_item(OP_INSERT, 32'hFFFF_FFFF);
                add_item(OP_QUERY, 32'h0);
            end
            add_random(PHASE_ITEMS);
            drain();
        end

        drain();
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
